// ===== hw/rtl/bcet_pkg.sv =====
// ----------------------------------------------------------------------------
// bcet_pkg
// Shared types and constants for the box contact event tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcet_pkg;

  localparam int PAIR_SLOTS_DEF = 1024;
  localparam int SLOT_IN_W      = 10;
  localparam int VEC_W          = 48;
  localparam int LANE_W         = 16;
  localparam int OVER_W         = 17;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } ev_t;

  typedef struct packed {
    logic [SLOT_IN_W-1:0] pair_slot;
    logic                 both_active;
    logic [VEC_W-1:0]     centre_a;
    logic [VEC_W-1:0]     centre_b;
    logic [VEC_W-1:0]     extent_a;
    logic [VEC_W-1:0]     extent_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        contact_event;
    logic              touching;
    logic [OVER_W-1:0] overlap_x;
    logic [OVER_W-1:0] overlap_z;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bcet_ram.sv =====
// ----------------------------------------------------------------------------
// bcet_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcet_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/box_contact_event_tracker.sv =====
// ----------------------------------------------------------------------------
// box_contact_event_tracker
// AABB pair overlap test with a per-pair contact flag: enter/stay/exit events.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the item transfers at a rising edge where
//   start is high and busy is low. One result per item appears on out_item
//   for exactly one cycle with out_valid high; the receiver cannot stall it.
//   The item is registered at the transfer edge, passes through the CALC and
//   UPD states, and the result is registered into out_item from UPD.
//   A new item is taken only once the last is through. Each item makes one
//   read-modify-write of its contact flag in the flag RAM (registered read),
//   so busy stays high through the read, the update and the write-back.
//   pair_slot is reduced modulo PAIR_SLOTS before addressing the flag RAM.
//   Reset (rst_n low, synchronous) starts a clearing pass that writes every
//   flag to zero, one entry per cycle, busy high meanwhile.
//   out_valid is low during and right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_contact_event_tracker
  import bcet_pkg::*;
#(
  parameter int PAIR_SLOTS = PAIR_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC, S_UPD} state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;
  in_item_t            item_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                active_r;
  logic                touch_r;
  logic [OVER_W-1:0]   ox_r, oz_r;

  logic [SLOT_W-1:0]   slot_calc;
  logic [OVER_W:0]     ax_x, ax_y, ax_z;
  logic                touch_calc;
  logic                flag_rd;
  logic                flag_new;
  ev_t                 ev;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [0:0]          ram_wdata;
  logic [0:0]          ram_rdata;

  // returns {hit, overlap}
  function automatic logic [OVER_W:0] axis_over(
    input logic [LANE_W-1:0] ca,
    input logic [LANE_W-1:0] cb,
    input logic [LANE_W-1:0] ea,
    input logic [LANE_W-1:0] eb
  );
    logic signed [LANE_W:0] diff;
    logic [LANE_W:0]        d, ma, mb;
    logic [LANE_W+1:0]      s, d2;
    diff = $signed({ca[LANE_W-1], ca}) - $signed({cb[LANE_W-1], cb});
    d    = diff[LANE_W] ? (LANE_W+1)'(-diff) : (LANE_W+1)'(diff);
    ma   = ea[LANE_W-1] ? (LANE_W+1)'(-$signed({ea[LANE_W-1], ea})) : {1'b0, ea};
    mb   = eb[LANE_W-1] ? (LANE_W+1)'(-$signed({eb[LANE_W-1], eb})) : {1'b0, eb};
    s    = {1'b0, ma} + {1'b0, mb};
    d2   = {d, 1'b0};
    if (s >= d2) begin
      return {1'b1, OVER_W'(s - d2)};
    end
    return '0;
  endfunction

  // slot = pair_slot mod PAIR_SLOTS by shifted compare-subtract
  always_comb begin
    logic [SLOT_IN_W-1:0] v;
    v = item_r.pair_slot;
    for (int k = SLOT_IN_W - 1; k >= 0; k--) begin
      if ((longint'(PAIR_SLOTS) << k) <= longint'(v)) begin
        v = v - SLOT_IN_W'(longint'(PAIR_SLOTS) << k);
      end
    end
    slot_calc = SLOT_W'(v);
  end

  assign ax_x = axis_over(item_r.centre_a[15:0], item_r.centre_b[15:0],
                          item_r.extent_a[15:0], item_r.extent_b[15:0]);
  assign ax_y = axis_over(item_r.centre_a[31:16], item_r.centre_b[31:16],
                          item_r.extent_a[31:16], item_r.extent_b[31:16]);
  assign ax_z = axis_over(item_r.centre_a[47:32], item_r.centre_b[47:32],
                          item_r.extent_a[47:32], item_r.extent_b[47:32]);
  assign touch_calc = ax_x[OVER_W] & ax_y[OVER_W] & ax_z[OVER_W];

  assign flag_rd = ram_rdata[0];

  always_comb begin
    ev       = EV_NONE;
    flag_new = 1'b0;
    priority if (touch_r && flag_rd) begin
      ev       = active_r ? EV_STAY : EV_EXIT;
      flag_new = active_r;
    end else if (touch_r) begin
      ev       = active_r ? EV_ENTER : EV_NONE;
      flag_new = active_r;
    end else if (flag_rd) begin
      ev       = EV_EXIT;
      flag_new = 1'b0;
    end else begin
      ev       = EV_NONE;
      flag_new = 1'b0;
    end
  end

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_UPD);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : slot_r;
  assign ram_wdata = (state_r == S_CLEAR) ? 1'b0 : flag_new;

  bcet_ram #(
    .WIDTH (1),
    .DEPTH (PAIR_SLOTS)
  ) u_flag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_calc),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == SLOT_W'(PAIR_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt                  = S_IDLE;
        out_valid_nxt              = 1'b1;
        out_item_nxt.contact_event = ev;
        out_item_nxt.touching      = touch_r;
        out_item_nxt.overlap_x     = ox_r;
        out_item_nxt.overlap_z     = oz_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      item_r <= in_item;
    end
    if (state_r == S_CALC) begin
      slot_r   <= slot_calc;
      active_r <= item_r.both_active;
      touch_r  <= touch_calc;
      ox_r     <= touch_calc ? ax_x[OVER_W-1:0] : '0;
      oz_r     <= touch_calc ? ax_z[OVER_W-1:0] : '0;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result not delivered three cycles after transfer");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_UPD))
    else $error("result strobe without flag update");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_enter_stay_touching: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.contact_event == EV_ENTER ||
                   out_item.contact_event == EV_STAY)) |-> out_item.touching)
    else $error("enter or stay event without contact");

endmodule

`default_nettype wire
